// ===== rtl/lmpd_pkg.sv =====
`timescale 1ns / 1ps
package lmpd_pkg;

  localparam int FRAC_BITS_DEF  = 20;
  localparam int DIST_WIDTH_DEF = 24;
  localparam int VEL_W          = 24;
  localparam int PRES_W         = 32;
  localparam int PSUM_W         = 48;
  localparam int CFG_W          = 24;
  localparam int GLEN_W         = 13;
  localparam int XPOS_W         = 12;
  localparam int DIR_W          = 5;
  localparam int OUT_DATA_W     = 152;
  localparam int OUT_USER_W     = 2;

  localparam logic [DIR_W-1:0] DIR_LAST = 5'd18;

  localparam logic [CFG_W-1:0]  SOUND_SPEED_SQ_RST = 24'd349525;
  localparam logic [CFG_W-1:0]  REST_DENSITY_RST   = 24'd1048576;
  localparam logic [GLEN_W-1:0] GRID_LENGTH_X_RST  = 13'd64;

  localparam logic [1:0] REG_SOUND_SPEED_SQ = 2'd0;
  localparam logic [1:0] REG_REST_DENSITY   = 2'd1;
  localparam logic [1:0] REG_GRID_LENGTH_X  = 2'd2;

  localparam logic [18:0] MASK_XP = 19'h04C82;
  localparam logic [18:0] MASK_XM = 19'h03308;
  localparam logic [18:0] MASK_YP = 19'h18184;
  localparam logic [18:0] MASK_YM = 19'h60610;
  localparam logic [18:0] MASK_ZP = 19'h4E020;
  localparam logic [18:0] MASK_ZM = 19'h31840;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MUL,
    ST_PRES,
    ST_SUM,
    ST_DROP,
    ST_DINIT,
    ST_DSTEP,
    ST_DSTORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       accum;
    logic       close;
    logic       mul;
    logic       pres;
    logic       psum;
    logic       drop;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       load_out;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic dir_ok;
    logic dir_last;
    logic skip_div;
    logic out_free;
  } sts_t;

  // 2'b01 adds, 2'b10 subtracts
  function automatic logic [1:0] axis_sign(input logic [DIR_W-1:0] dir,
                                           input logic [18:0] mp,
                                           input logic [18:0] mm);
    logic [1:0] s;
    s = 2'b00;
    if (dir <= DIR_LAST) begin
      s = {mm[dir], mp[dir]};
    end
    return s;
  endfunction

endpackage

// ===== rtl/lmpd_ctrl.sv =====
`timescale 1ns / 1ps
module lmpd_ctrl #(
  parameter int NUM_W = lmpd_pkg::DIST_WIDTH_DEF + 5 + lmpd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  lmpd_pkg::sts_t sts,
  output logic          in_ready,
  output lmpd_pkg::cmd_t cmd
);

  localparam int CW = $clog2(NUM_W + 1);

  lmpd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmpd_pkg::ST_ACC;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    in_ready  = 1'b0;
    case (state_r)
      lmpd_pkg::ST_ACC: begin
        in_ready  = 1'b1;
        cmd.accum = in_fire && sts.dir_ok;
        cmd.close = in_fire && sts.dir_last;
        if (cmd.close) begin
          state_nxt = lmpd_pkg::ST_MUL;
        end
      end
      lmpd_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lmpd_pkg::ST_PRES;
      end
      lmpd_pkg::ST_PRES: begin
        cmd.pres  = 1'b1;
        state_nxt = lmpd_pkg::ST_SUM;
      end
      lmpd_pkg::ST_SUM: begin
        cmd.psum  = 1'b1;
        state_nxt = lmpd_pkg::ST_DROP;
      end
      lmpd_pkg::ST_DROP: begin
        cmd.drop  = 1'b1;
        axis_nxt  = '0;
        state_nxt = sts.skip_div ? lmpd_pkg::ST_OUT : lmpd_pkg::ST_DINIT;
      end
      lmpd_pkg::ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = lmpd_pkg::ST_DSTEP;
      end
      lmpd_pkg::ST_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          state_nxt = lmpd_pkg::ST_DSTORE;
        end
      end
      lmpd_pkg::ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = lmpd_pkg::ST_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = lmpd_pkg::ST_DINIT;
        end
      end
      lmpd_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = lmpd_pkg::ST_ACC;
        end
      end
      default: state_nxt = lmpd_pkg::ST_ACC;
    endcase
  end

endmodule

// ===== rtl/lmpd_dpath.sv =====
`timescale 1ns / 1ps
module lmpd_dpath #(
  parameter int FRAC_BITS  = lmpd_pkg::FRAC_BITS_DEF,
  parameter int DIST_WIDTH = lmpd_pkg::DIST_WIDTH_DEF,
  parameter int NUM_W      = DIST_WIDTH + 5 + FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [DIST_WIDTH-1:0]         dist_value,
  input  logic [lmpd_pkg::DIR_W-1:0]           direction,
  input  logic [lmpd_pkg::XPOS_W-1:0]          x_pos,
  input  logic                                 obstacle,
  input  logic                                 last_node,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_idx,
  input  logic [lmpd_pkg::CFG_W-1:0]           cfg_wdata,
  input  lmpd_pkg::cmd_t                       cmd,
  input  logic                                 out_ready,
  output lmpd_pkg::sts_t                       sts,
  output logic                                 out_valid,
  output logic [lmpd_pkg::OUT_DATA_W-1:0]      out_data,
  output logic [lmpd_pkg::OUT_USER_W-1:0]      out_user
);

  localparam int SW = DIST_WIDTH + 5;
  localparam int AW = (SW > lmpd_pkg::CFG_W) ? SW : lmpd_pkg::CFG_W;
  localparam int PW = AW + lmpd_pkg::CFG_W;
  localparam int VW = lmpd_pkg::VEL_W;

  logic [lmpd_pkg::CFG_W-1:0]  css_r, rest_r;
  logic [lmpd_pkg::GLEN_W-1:0] glen_r;

  logic signed [SW-1:0] dens_r, mx_r, my_r, mz_r;
  logic signed [SW-1:0] fx;
  logic [1:0] sx, sy, sz;

  logic obst_r, last_r, zero_r, neg_r;
  logic [lmpd_pkg::XPOS_W-1:0] x_r;
  logic [SW-1:0] dabs_r;
  logic [PW-1:0] prod_r;
  logic signed [lmpd_pkg::PRES_W-1:0] pr_r, pr_nxt;
  logic signed [lmpd_pkg::PSUM_W-1:0] isum_r, osum_r, drop_r;

  logic [NUM_W-1:0] num_r;
  logic [SW-1:0]    rem_r;
  logic [VW-1:0]    quo_r;
  logic             ovf_r;
  logic signed [SW-1:0] mom_sel;
  logic [SW:0]      trial;
  logic             ge;

  logic signed [VW-1:0] vx_r, vy_r, vz_r;
  logic out_valid_r;
  logic [lmpd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [lmpd_pkg::OUT_USER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      css_r  <= lmpd_pkg::SOUND_SPEED_SQ_RST;
      rest_r <= lmpd_pkg::REST_DENSITY_RST;
      glen_r <= lmpd_pkg::GRID_LENGTH_X_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lmpd_pkg::REG_SOUND_SPEED_SQ: css_r  <= cfg_wdata;
        lmpd_pkg::REG_REST_DENSITY:   rest_r <= cfg_wdata;
        lmpd_pkg::REG_GRID_LENGTH_X:  glen_r <= cfg_wdata[lmpd_pkg::GLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign fx = SW'(dist_value);
  assign sx = lmpd_pkg::axis_sign(direction, lmpd_pkg::MASK_XP, lmpd_pkg::MASK_XM);
  assign sy = lmpd_pkg::axis_sign(direction, lmpd_pkg::MASK_YP, lmpd_pkg::MASK_YM);
  assign sz = lmpd_pkg::axis_sign(direction, lmpd_pkg::MASK_ZP, lmpd_pkg::MASK_ZM);

  assign sts.dir_ok   = direction <= lmpd_pkg::DIR_LAST;
  assign sts.dir_last = direction == lmpd_pkg::DIR_LAST;
  assign sts.skip_div = obst_r || zero_r;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dens_r <= '0;
      mx_r   <= '0;
      my_r   <= '0;
      mz_r   <= '0;
    end else if (cmd.load_out) begin
      dens_r <= '0;
      mx_r   <= '0;
      my_r   <= '0;
      mz_r   <= '0;
    end else if (cmd.accum) begin
      dens_r <= dens_r + fx;
      if (sx[0]) mx_r <= mx_r + fx;
      if (sx[1]) mx_r <= mx_r - fx;
      if (sy[0]) my_r <= my_r + fx;
      if (sy[1]) my_r <= my_r - fx;
      if (sz[0]) mz_r <= mz_r + fx;
      if (sz[1]) mz_r <= mz_r - fx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      obst_r <= obstacle;
      last_r <= last_node;
      x_r    <= x_pos;
    end
    if (cmd.mul) begin
      zero_r <= !obst_r && (dens_r == '0);
      neg_r  <= !obst_r && dens_r[SW-1];
      dabs_r <= dens_r[SW-1] ? SW'(-dens_r) : SW'(dens_r);
      if (obst_r) begin
        prod_r <= PW'(AW'(rest_r) * AW'(css_r));
      end else begin
        prod_r <= PW'(AW'(dens_r[SW-1] ? SW'(-dens_r) : SW'(dens_r)) * AW'(css_r));
      end
    end
    if (cmd.pres) begin
      pr_r <= pr_nxt;
    end
  end

  always_comb begin
    logic [PW:0] pm;
    pm = ({1'b0, prod_r} + (neg_r ? (PW+1)'({FRAC_BITS{1'b1}}) : '0)) >> FRAC_BITS;
    if (zero_r) begin
      pr_nxt = '0;
    end else if (!neg_r) begin
      pr_nxt = (pm > (PW+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : pm[31:0];
    end else begin
      pr_nxt = (pm > (PW+1)'(33'h0_8000_0000)) ? 32'sh8000_0000 : -pm[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r <= '0;
      osum_r <= '0;
    end else if (cmd.psum) begin
      if (x_r == lmpd_pkg::XPOS_W'(1)) begin
        isum_r <= isum_r + lmpd_pkg::PSUM_W'(pr_r);
      end
      if ({2'b00, x_r} == ({1'b0, glen_r} - 14'd2)) begin
        osum_r <= osum_r + lmpd_pkg::PSUM_W'(pr_r);
      end
    end else if (cmd.drop && last_r) begin
      isum_r <= '0;
      osum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      drop_r <= last_r ? isum_r - osum_r : '0;
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0:    mom_sel = mx_r;
      2'd1:    mom_sel = my_r;
      default: mom_sel = mz_r;
    endcase
  end

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, dabs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= {(mom_sel[SW-1] ? SW'(-mom_sel) : SW'(mom_sel)), {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? SW'(trial - {1'b0, dabs_r}) : trial[SW-1:0];
      quo_r <= {quo_r[VW-2:0], ge};
      ovf_r <= ovf_r | quo_r[VW-1];
    end
  end

  always_ff @(posedge clk) begin
    logic           neg;
    logic [VW-1:0]  lim, mag;
    neg = mom_sel[SW-1] ^ dens_r[SW-1];
    lim = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    mag = (ovf_r || quo_r > lim) ? lim : quo_r;
    if (cmd.close) begin
      vx_r <= '0;
      vy_r <= '0;
      vz_r <= '0;
    end else if (cmd.div_store) begin
      case (cmd.axis)
        2'd0:    vx_r <= neg ? -mag : mag;
        2'd1:    vy_r <= neg ? -mag : mag;
        default: vz_r <= neg ? -mag : mag;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {drop_r, pr_r, vz_r, vy_r, vx_r};
      out_user_r <= {last_r, zero_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

// ===== rtl/lattice_moment_pressure_drop_core.sv =====
`timescale 1ns / 1ps
// D3Q19 node moments with inlet/outlet pressure drop.
// in_*: one distribution per transfer, directions 0 to 18 of a node in turn;
//   in_tdata = {x_pos, dist_value}, in_tuser = {obstacle, direction},
//   in_tlast = last node of the sweep. Directions above 18 are dropped.
// out_*: one transfer per node, after its direction 18 item.
// cfg_*: register writes (0 sound speed squared, 1 rest density, 2 grid length x),
//   taken at once; the user must write only while the block is idle (not enforced).
// Directions 0 to 17 are taken one per cycle. Direction 18 closes the node:
// a multiply and the pressure slice update come first, then one shared
// restoring divider computes the velocities one axis after another
// (skipped on obstacle or zero-density nodes) before the result is
// registered; in_tready is low meanwhile. A held result is kept in the
// output register while the next node streams in; in_tready stays low past
// the next node's computation only while the receiver has not yet taken
// the previous result.
// Reset clears all sums, restores register defaults and empties the output.
module lattice_moment_pressure_drop_core #(
  parameter int FRAC_BITS  = lmpd_pkg::FRAC_BITS_DEF,
  parameter int DIST_WIDTH = lmpd_pkg::DIST_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DIST_WIDTH+19)/8)*8-1:0]    in_tdata,  // dist_value, x_pos
  input  logic [5:0]                          in_tuser,  // direction, obstacle
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // vel_x, vel_y, vel_z, node_pressure, pressure_drop
  output logic [lmpd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [lmpd_pkg::OUT_USER_W-1:0]     out_tuser, // zero_density, drop_valid
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [lmpd_pkg::CFG_W-1:0]          cfg_data
);

  localparam int NUM_W = DIST_WIDTH + 5 + FRAC_BITS;

  lmpd_pkg::cmd_t cmd;
  lmpd_pkg::sts_t sts;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  lmpd_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  lmpd_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .DIST_WIDTH(DIST_WIDTH),
    .NUM_W     (NUM_W)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dist_value(in_tdata[DIST_WIDTH-1:0]),
    .direction (in_tuser[4:0]),
    .x_pos     (in_tdata[DIST_WIDTH +: lmpd_pkg::XPOS_W]),
    .obstacle  (in_tuser[5]),
    .last_node (in_tlast),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

  a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[103:0] == '0)
    else $error("zero density result carries non-zero velocity or pressure");

  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[151:104] == '0)
    else $error("pressure drop set without drop_valid");

  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[4:0] == lmpd_pkg::DIR_LAST |=> !in_tready)
    else $error("input taken while node result is being computed");

endmodule
